// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by trusted_mac_table_lru.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/tmtl_pkg.sv =====
// Types and constants of the trusted address table.
`default_nettype none

package tmtl_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int ADDR_W    = 48;
  localparam int STAMP_W   = 32;
  localparam int IDX_W     = 3;

  localparam logic FUNC_CHECK = 1'b0;
  localparam logic FUNC_PAIR  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic               func;
    logic [ADDR_W-1:0]  sender;
    logic [STAMP_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic             accepted;
    logic             hit;
    logic [IDX_W-1:0] slot_index;
    logic             wrote_entry;
    logic             evicted_valid;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/trusted_mac_table_lru.sv =====
// Trusted source address table: lookup, stamp refresh and LRU replacement.
// A request is taken while idle; the block scans every slot, then writes and raises done.
// It takes no new request while busy; the scan reads one slot per cycle from the
//   address and stamp RAMs through a single compare unit.
// Reset (synchronous, active high) clears all valid bits, so the table is empty.
// Results are strobed on done for one cycle; the receiver cannot stall.
`default_nettype none
`include "assert_macros.svh"

module trusted_mac_table_lru #(
  parameter int SLOTS = tmtl_pkg::SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire tmtl_pkg::req_t req,
  output logic               done,
  output tmtl_pkg::rsp_t     rsp
);

  import tmtl_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  state_t state, state_next;
  logic [CW-1:0]      cnt;
  logic [SLOTS-1:0]   valid;
  req_t               item;

  logic               found;
  logic               empty_found;
  logic [IW-1:0]      match_idx;
  logic [IW-1:0]      empty_idx;
  logic [IW-1:0]      min_idx;
  logic [STAMP_W-1:0] min_stamp;

  logic [ADDR_W-1:0]  addr_rd;
  logic [STAMP_W-1:0] stamp_rd;
  logic [IW-1:0]      rd_idx;
  logic [IW-1:0]      cur_idx;
  logic [IW-1:0]      victim_idx;
  logic [IW-1:0]      wr_idx;
  logic               addr_we;
  logic               stamp_we;
  logic               take;
  logic               scan_last;
  rsp_t               rsp_next;
  logic [IW+2:0]      match_ext;
  logic [IW+2:0]      victim_ext;

  assign take      = start && !busy;
  assign scan_last = (cnt == CW'(SLOTS));
  assign cur_idx   = IW'(cnt - CW'(1));
  assign rd_idx    = (cnt < CW'(SLOTS)) ? IW'(cnt) : '0;
  assign victim_idx = empty_found ? empty_idx : min_idx;
  assign match_ext  = {3'b000, match_idx};
  assign victim_ext = {3'b000, victim_idx};

  tmtl_ram #(.WIDTH(ADDR_W), .DEPTH(SLOTS), .AW(IW)) u_addr_ram (
    .clk   (clk),
    .we    (addr_we),
    .waddr (wr_idx),
    .wdata (item.sender),
    .raddr (rd_idx),
    .rdata (addr_rd)
  );

  tmtl_ram #(.WIDTH(STAMP_W), .DEPTH(SLOTS), .AW(IW)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (wr_idx),
    .wdata (item.now_ms),
    .raddr (rd_idx),
    .rdata (stamp_rd)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (take) state_next = ST_SCAN;
      ST_SCAN:  if (scan_last) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs and table updates.
  always_comb begin
    busy     = (state != ST_IDLE);
    addr_we  = 1'b0;
    stamp_we = 1'b0;
    wr_idx   = found ? match_idx : victim_idx;
    rsp_next = '0;
    case (state)
      ST_WRITE: begin
        if (found) begin
          stamp_we            = (item.func == FUNC_CHECK);
          rsp_next.accepted   = 1'b1;
          rsp_next.hit        = 1'b1;
          rsp_next.slot_index = match_ext[2:0];
        end else if (item.func == FUNC_PAIR) begin
          addr_we                = 1'b1;
          stamp_we               = 1'b1;
          rsp_next.accepted      = 1'b1;
          rsp_next.wrote_entry   = 1'b1;
          rsp_next.slot_index    = victim_ext[2:0];
          rsp_next.evicted_valid = !empty_found;
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      valid       <= '0;
      done        <= 1'b0;
      found       <= 1'b0;
      empty_found <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_WRITE);
      case (state)
        ST_IDLE: begin
          cnt         <= '0;
          found       <= 1'b0;
          empty_found <= 1'b0;
        end
        ST_SCAN: begin
          cnt <= cnt + CW'(1);
          // Read data is registered and arrives in the cycle after its read address.
          if (cnt != '0) begin
            if (valid[cur_idx] && addr_rd == item.sender && !found) begin
              found <= 1'b1;
            end
            if (!valid[cur_idx] && !empty_found) begin
              empty_found <= 1'b1;
            end
          end
        end
        ST_WRITE: begin
          if (addr_we) begin
            valid[wr_idx] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (take) begin
      item <= req;
    end
    if (state == ST_SCAN && cnt != '0) begin
      if (valid[cur_idx] && addr_rd == item.sender && !found) begin
        match_idx <= cur_idx;
      end
      if (!valid[cur_idx] && !empty_found) begin
        empty_idx <= cur_idx;
      end
      // Strict less keeps the lowest index on ties; slot 0 seeds the minimum.
      if (cnt == CW'(1) || stamp_rd < min_stamp) begin
        min_stamp <= stamp_rd;
        min_idx   <= cur_idx;
      end
    end
    if (state == ST_WRITE) begin
      rsp <= rsp_next;
    end
  end

  `ASSERT_NEXT(a_take_busy, clk, rst, take, busy)
  `ASSERT_NEXT(a_write_done, clk, rst, state == ST_WRITE, done && !busy)
  `ASSERT_IMPLIES(a_hit_no_write, clk, rst, done && rsp.hit,
                  rsp.accepted && !rsp.wrote_entry && !rsp.evicted_valid)
  `ASSERT_IMPLIES(a_write_accepts, clk, rst, done && rsp.wrote_entry,
                  rsp.accepted && !rsp.hit)

endmodule

`default_nettype wire

// ===== hw/rtl/tmtl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tmtl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
